/* rtl/core/voxel_cube_draw_engine_core_macros.svh */
// assertion helpers for the voxel cube draw engine
`ifndef VOXEL_CUBE_DRAW_ENGINE_CORE_MACROS_SVH
`define VOXEL_CUBE_DRAW_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VCDE_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vcde same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define VCDE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vcde next-cycle check failed");

`endif

/* rtl/core/vcde_pkg.sv */
package vcde_pkg;

    typedef enum logic [3:0] {
        OP_SET     = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_FLIP    = 4'd2,
        OP_READ    = 4'd3,
        OP_PLANE   = 4'd4,
        OP_LINE    = 4'd5,
        OP_DIAG    = 4'd6,
        OP_FILL    = 4'd7,
        OP_SAVE    = 4'd8,
        OP_RESTORE = 4'd9
    } op_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_TRACE = 2'd1,
        ST_WALK  = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

endpackage

/* rtl/core/voxel_cube_draw_engine_core.sv */
// after an input transfer the block walks both row memories, one row per cycle, then raises m_valid
// diagonal commands first trace their line, one line point per cycle, before the row walk
// a new command is taken only after the row walk over the two row memories is done and its result is registered
// reset: synchronous active-low, per-row valid flags make both stores read as zero
// no clearing pass after reset, the block is ready as soon as reset is released
module voxel_cube_draw_engine_core
    import vcde_pkg::*;
#(
    parameter int CUBE_SIZE = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_operation,
    input  logic signed [3:0] s_x,
    input  logic signed [3:0] s_y,
    input  logic signed [3:0] s_z,
    input  logic signed [3:0] s_end_a,
    input  logic signed [3:0] s_end_b,
    input  logic [1:0]        s_axis,
    input  logic              s_draw_state,
    input  logic [4:0]        s_pattern,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_voxel_value
);

    localparam int ROWS   = CUBE_SIZE * CUBE_SIZE;
    localparam int ADDR_W = $clog2(ROWS);
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int IDX_W  = $clog2(CUBE_SIZE);
    localparam int ROW_W  = CUBE_SIZE;

    function automatic logic coord_ok(input logic [3:0] v);
        return (v[3] == 1'b0) && ({1'b0, v} < 5'(CUBE_SIZE));
    endfunction

    function automatic logic coord_eq(input logic [3:0] v, input logic [IDX_W-1:0] c);
        return (v[3] == 1'b0) && ({1'b0, v} == 5'(c));
    endfunction

    function automatic logic [ROW_W-1:0] bit_of(input logic [3:0] v);
        return ROW_W'(1) << v[2:0];
    endfunction

    function automatic logic in_span(input logic [IDX_W-1:0] c,
                                     input logic [3:0] lo, input logic [3:0] hi);
        logic signed [5:0] cv;
        logic signed [5:0] lv;
        logic signed [5:0] hv;
        cv = 6'(c);
        lv = {{2{lo[3]}}, lo};
        hv = {{2{hi[3]}}, hi};
        return (cv >= lv) && (cv <= hv);
    endfunction

    // row memories
    logic [ROW_W-1:0] vox_mem [ROWS];
    logic [ROW_W-1:0] sav_mem [ROWS];

    state_t state_reg, state_next;

    // command registers
    op_t               op_reg;
    logic signed [3:0] x_reg, y_reg, z_reg;
    logic [1:0]        axis_reg;
    logic              on_reg;
    logic [4:0]        pat_reg;
    logic signed [3:0] lo_reg, hi_reg;

    // line tracer
    logic signed [3:0] a_reg, a_next, b_reg, b_next;
    logic [4:0]        acc_reg, acc_next;
    logic [3:0]        den_reg, add_reg;
    logic [3:0]        left_reg, left_next;
    logic              maj_a_reg, sa_neg_reg, sb_neg_reg;
    logic [ROWS-1:0]   lm_reg, lm_next;

    // row walk
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  ry_reg, ry_next, rz_reg, rz_next;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
    logic              p_valid_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic [IDX_W-1:0]  p_y_reg, p_z_reg;
    logic [ROW_W-1:0]  vox_q_reg, sav_q_reg;
    logic              vox_ok_reg, sav_ok_reg;
    logic [ROWS-1:0]   vox_vld_reg, vox_vld_next, sav_vld_reg, sav_vld_next;

    logic              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_value_reg, m_value_next;

    logic              accept, out_free;
    logic [ROW_W-1:0]  cur, sav_cur, cur_sh, mask, span_mask, new_row;
    logic              hit, vox_we, sav_we;

    // accept-side decode
    logic signed [4:0] da5, db5;
    logic [3:0]        da, db;
    logic              maj_a_in;
    logic signed [3:0] start_in, lo_in, hi_in;
    logic              mark_ok, carry;
    logic [4:0]        acc_sum;
    logic [ADDR_W-1:0] lm_idx;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (state_reg == ST_WALK) && (cnt_reg != CNT_W'(ROWS));
    assign rd_addr  = cnt_reg[ADDR_W-1:0];

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_voxel_value = m_value_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (op_t'(s_operation) == OP_DIAG) ? ST_TRACE : ST_WALK;
                end
            end
            ST_TRACE: begin
                if (left_reg == 4'd0) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cnt_reg == CNT_W'(ROWS)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // accept decode
    always_comb begin
        da5 = {s_end_a[3], s_end_a} - {s_x[3], s_x};
        db5 = {s_end_b[3], s_end_b} - {s_y[3], s_y};
        da  = da5[4] ? 4'(-da5) : da5[3:0];
        db  = db5[4] ? 4'(-db5) : db5[3:0];
        maj_a_in = (da >= db);
        case (s_axis)
            AXIS_X:  start_in = s_x;
            AXIS_Y:  start_in = s_y;
            default: start_in = s_z;
        endcase
        lo_in = (start_in < s_end_a) ? start_in : s_end_a;
        hi_in = (start_in < s_end_a) ? s_end_a : start_in;
    end

    // line tracer step
    always_comb begin
        acc_sum   = acc_reg + {1'b0, add_reg};
        carry     = (acc_sum >= {1'b0, den_reg});
        acc_next  = carry ? (acc_sum - {1'b0, den_reg}) : acc_sum;
        a_next    = a_reg;
        b_next    = b_reg;
        left_next = left_reg - 4'd1;
        if (maj_a_reg || carry) begin
            a_next = a_reg + (sa_neg_reg ? 4'sb1111 : 4'sb0001);
        end
        if (!maj_a_reg || carry) begin
            b_next = b_reg + (sb_neg_reg ? 4'sb1111 : 4'sb0001);
        end
        mark_ok = coord_ok(a_reg) && coord_ok(b_reg);
        lm_idx  = ADDR_W'(32'(b_reg[2:0]) * CUBE_SIZE + 32'(a_reg[2:0]));
        lm_next = lm_reg;
        if (accept) begin
            lm_next = '0;
        end else if ((state_reg == ST_TRACE) && mark_ok) begin
            lm_next[lm_idx] = 1'b1;
        end
    end

    // walk counters
    always_comb begin
        cnt_next = cnt_reg;
        ry_next  = ry_reg;
        rz_next  = rz_reg;
        if (accept) begin
            cnt_next = '0;
            ry_next  = '0;
            rz_next  = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (ry_reg == IDX_W'(CUBE_SIZE - 1)) begin
                ry_next = '0;
                rz_next = rz_reg + IDX_W'(1);
            end else begin
                ry_next = ry_reg + IDX_W'(1);
            end
        end
    end

    // row update
    always_comb begin
        cur     = vox_ok_reg ? vox_q_reg : '0;
        sav_cur = sav_ok_reg ? sav_q_reg : '0;
        cur_sh  = cur >> x_reg[2:0];
        hit     = coord_ok(x_reg) && coord_eq(y_reg, p_y_reg) && coord_eq(z_reg, p_z_reg);
        for (int i = 0; i < ROW_W; i++) begin
            span_mask[i] = in_span(IDX_W'(i), lo_reg, hi_reg);
        end
        mask    = '0;
        new_row = cur;
        vox_we  = 1'b0;
        sav_we  = 1'b0;
        case (op_reg)
            OP_SET: begin
                vox_we  = 1'b1;
                new_row = hit ? (cur | bit_of(x_reg)) : cur;
            end
            OP_CLEAR: begin
                vox_we  = 1'b1;
                new_row = hit ? (cur & ~bit_of(x_reg)) : cur;
            end
            OP_FLIP: begin
                vox_we  = 1'b1;
                new_row = hit ? (cur ^ bit_of(x_reg)) : cur;
            end
            OP_PLANE: begin
                vox_we = 1'b1;
                case (axis_reg)
                    AXIS_X:  mask = coord_ok(x_reg) ? bit_of(x_reg) : '0;
                    AXIS_Y:  mask = coord_eq(x_reg, p_y_reg) ? '1 : '0;
                    AXIS_Z:  mask = coord_eq(x_reg, p_z_reg) ? '1 : '0;
                    default: mask = '0;
                endcase
                new_row = on_reg ? (cur | mask) : (cur & ~mask);
            end
            OP_LINE: begin
                vox_we = 1'b1;
                case (axis_reg)
                    AXIS_X: begin
                        if (coord_eq(y_reg, p_y_reg) && coord_eq(z_reg, p_z_reg)) begin
                            mask = span_mask;
                        end
                    end
                    AXIS_Y: begin
                        if (coord_ok(x_reg) && coord_eq(z_reg, p_z_reg)
                            && in_span(p_y_reg, lo_reg, hi_reg)) begin
                            mask = bit_of(x_reg);
                        end
                    end
                    AXIS_Z: begin
                        if (coord_ok(x_reg) && coord_eq(y_reg, p_y_reg)
                            && in_span(p_z_reg, lo_reg, hi_reg)) begin
                            mask = bit_of(x_reg);
                        end
                    end
                    default: mask = '0;
                endcase
                new_row = on_reg ? (cur | mask) : (cur & ~mask);
            end
            OP_DIAG: begin
                vox_we = 1'b1;
                case (axis_reg)
                    AXIS_X:  mask = lm_reg[32'(p_z_reg) * CUBE_SIZE +: CUBE_SIZE];
                    AXIS_Y:  mask = lm_reg[ADDR_W'(32'(p_y_reg) * CUBE_SIZE + 32'(p_z_reg))]
                                    ? '1 : '0;
                    AXIS_Z:  mask = lm_reg[32'(p_y_reg) * CUBE_SIZE +: CUBE_SIZE];
                    default: mask = '0;
                endcase
                new_row = cur | mask;
            end
            OP_FILL: begin
                vox_we  = 1'b1;
                new_row = ROW_W'(pat_reg);
            end
            OP_SAVE: begin
                sav_we = 1'b1;
            end
            OP_RESTORE: begin
                vox_we  = 1'b1;
                new_row = sav_cur;
            end
            default: begin
                new_row = cur;
            end
        endcase
        vox_we = vox_we && p_valid_reg;
        sav_we = sav_we && p_valid_reg;

        vox_vld_next = vox_vld_reg;
        sav_vld_next = sav_vld_reg;
        if (vox_we) begin
            vox_vld_next[p_addr_reg] = 1'b1;
        end
        if (sav_we) begin
            sav_vld_next[p_addr_reg] = 1'b1;
        end
    end

    // result and output register
    always_comb begin
        res_next = res_reg;
        if (accept) begin
            res_next = 1'b0;
        end else if (p_valid_reg && (op_reg == OP_READ) && hit) begin
            res_next = cur_sh[0];
        end
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
            m_value_next = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vox_vld_reg <= '0;
            sav_vld_reg <= '0;
            cnt_reg     <= '0;
            ry_reg      <= '0;
            rz_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
            m_valid_reg <= m_valid_next;
            vox_vld_reg <= vox_vld_next;
            sav_vld_reg <= sav_vld_next;
            cnt_reg     <= cnt_next;
            ry_reg      <= ry_next;
            rz_reg      <= rz_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_t'(s_operation);
            x_reg      <= s_x;
            y_reg      <= s_y;
            z_reg      <= s_z;
            axis_reg   <= s_axis;
            on_reg     <= s_draw_state;
            pat_reg    <= s_pattern;
            lo_reg     <= lo_in;
            hi_reg     <= hi_in;
            a_reg      <= s_x;
            b_reg      <= s_y;
            maj_a_reg  <= maj_a_in;
            sa_neg_reg <= da5[4];
            sb_neg_reg <= db5[4];
            den_reg    <= maj_a_in ? da : db;
            add_reg    <= maj_a_in ? db : da;
            left_reg   <= maj_a_in ? da : db;
            acc_reg    <= {2'b00, (maj_a_in ? da[3:1] : db[3:1])};
        end else if (state_reg == ST_TRACE) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
            left_reg <= left_next;
        end
        lm_reg      <= lm_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
        p_addr_reg  <= rd_addr;
        p_y_reg     <= ry_reg;
        p_z_reg     <= rz_reg;
    end

    // row memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (vox_we) begin
            vox_mem[p_addr_reg] <= new_row;
        end
        if (sav_we) begin
            sav_mem[p_addr_reg] <= cur;
        end
        vox_q_reg  <= vox_mem[rd_addr];
        sav_q_reg  <= sav_mem[rd_addr];
        vox_ok_reg <= vox_vld_reg[rd_addr];
        sav_ok_reg <= sav_vld_reg[rd_addr];
    end

endmodule

/* rtl/core/vcde_checker.sv */
`include "voxel_cube_draw_engine_core_macros.svh"

module vcde_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_voxel_value
);

    // a stalled result holds
    `VCDE_ASSERT_NEXT(chk_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_voxel_value))

    // busy after an input transfer
    `VCDE_ASSERT_NEXT(chk_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // returning to idle always presents a result
    `VCDE_ASSERT_NOW(chk_idle_brings_result, aclk, aresetn, $rose(s_ready), m_valid)

    // no new result appears while idle after a drain
    `VCDE_ASSERT_NEXT(chk_drain_in_idle, aclk, aresetn, m_valid && m_ready && s_ready, !m_valid)

endmodule

bind voxel_cube_draw_engine_core vcde_checker u_vcde_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_voxel_value (m_voxel_value)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import vcde_pkg::*;

    localparam int CUBE = 5;
    localparam int ROWS = CUBE * CUBE;
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [3:0]        op;
        logic signed [3:0] x;
        logic signed [3:0] y;
        logic signed [3:0] z;
        logic signed [3:0] end_a;
        logic signed [3:0] end_b;
        logic [1:0]        axis;
        logic              draw;
        logic [4:0]        pattern;
    } cmd_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_operation = '0;
    logic signed [3:0] s_x = '0;
    logic signed [3:0] s_y = '0;
    logic signed [3:0] s_z = '0;
    logic signed [3:0] s_end_a = '0;
    logic signed [3:0] s_end_b = '0;
    logic [1:0]        s_axis = '0;
    logic              s_draw_state = 1'b0;
    logic [4:0]        s_pattern = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_voxel_value;

    always #1 aclk = ~aclk;

    voxel_cube_draw_engine_core #(.CUBE_SIZE(CUBE)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_z           (s_z),
        .s_end_a       (s_end_a),
        .s_end_b       (s_end_b),
        .s_axis        (s_axis),
        .s_draw_state  (s_draw_state),
        .s_pattern     (s_pattern),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_voxel_value (m_voxel_value)
    );

    // shadow copy of the voxel buffer and its save copy
    logic [CUBE-1:0] shadow_rows [ROWS];
    logic [CUBE-1:0] shadow_saved [ROWS];

    cmd_t pend_q [$];
    logic voxel_exp_q [$];
    int   items_queued = 0;
    int   sent_cnt = 0;
    int   results_seen = 0;
    int   reads_lit = 0;
    int   errors = 0;

    function automatic bit in_cube(int x, int y, int z);
        return x >= 0 && x < CUBE && y >= 0 && y < CUBE && z >= 0 && z < CUBE;
    endfunction

    function automatic void shadow_put(int x, int y, int z, logic on);
        if (in_cube(x, y, z))
            shadow_rows[z * CUBE + y][x] = on;
    endfunction

    function automatic void shadow_plane(logic [1:0] ax, int idx, logic on);
        if (idx < 0 || idx >= CUBE || ax > AXIS_Z)
            return;
        for (int a = 0; a < CUBE; a++) begin
            for (int b = 0; b < CUBE; b++) begin
                if (ax == AXIS_X)
                    shadow_put(idx, a, b, on);
                else if (ax == AXIS_Y)
                    shadow_put(b, idx, a, on);
                else
                    shadow_put(b, a, idx, on);
            end
        end
    endfunction

    function automatic void shadow_line(logic [1:0] ax, int x, int y, int z, int e, logic on);
        int start;
        int lo;
        int hi;
        if (ax > AXIS_Z)
            return;
        start = (ax == AXIS_X) ? x : (ax == AXIS_Y) ? y : z;
        lo = (start < e) ? start : e;
        hi = (start < e) ? e : start;
        for (int i = lo; i <= hi; i++) begin
            if (ax == AXIS_X)
                shadow_put(i, y, z, 1'b1 & on);
            else if (ax == AXIS_Y)
                shadow_put(x, i, z, on);
            else
                shadow_put(x, y, i, on);
        end
    endfunction

    // bresenham in the (a,b) plane, extruded along z, y or x for the z, x or y anchor
    function automatic void shadow_diag(int a1, int b1, int a2, int b2, logic [1:0] ax);
        int da;
        int db;
        int sa;
        int sb;
        int a;
        int b;
        int acc_a;
        int acc_b;
        int each_a;
        int each_b;
        int den;
        int acc;
        int add;
        int count;
        if (ax > AXIS_Z)
            return;
        da = (a2 >= a1) ? a2 - a1 : a1 - a2;
        db = (b2 >= b1) ? b2 - b1 : b1 - b2;
        sa = (a2 >= a1) ? 1 : -1;
        sb = (b2 >= b1) ? 1 : -1;
        a = a1;
        b = b1;
        if (da >= db) begin
            acc_a = 0; acc_b = sb; each_a = sa; each_b = 0;
            den = da; add = db; count = da;
        end else begin
            acc_a = sa; acc_b = 0; each_a = 0; each_b = sb;
            den = db; add = da; count = db;
        end
        acc = den / 2;
        for (int p = 0; p <= count; p++) begin
            for (int k = 0; k < CUBE; k++) begin
                if (ax == AXIS_Z)
                    shadow_put(a, b, k, 1'b1);
                else if (ax == AXIS_X)
                    shadow_put(a, k, b, 1'b1);
                else
                    shadow_put(k, b, a, 1'b1);
            end
            acc += add;
            if (acc >= den) begin
                acc -= den;
                a += acc_a;
                b += acc_b;
            end
            a += each_a;
            b += each_b;
        end
    endfunction

    // updates the shadow buffer and returns the voxel bit the block should report
    function automatic logic draw_and_read(cmd_t c);
        int x;
        int y;
        int z;
        logic bit_out;
        x = int'(c.x);
        y = int'(c.y);
        z = int'(c.z);
        bit_out = 1'b0;
        case (c.op)
            OP_SET:   shadow_put(x, y, z, 1'b1);
            OP_CLEAR: shadow_put(x, y, z, 1'b0);
            OP_FLIP: begin
                if (in_cube(x, y, z))
                    shadow_rows[z * CUBE + y][x] = ~shadow_rows[z * CUBE + y][x];
            end
            OP_READ: begin
                if (in_cube(x, y, z))
                    bit_out = shadow_rows[z * CUBE + y][x];
            end
            OP_PLANE: shadow_plane(c.axis, x, c.draw);
            OP_LINE:  shadow_line(c.axis, x, y, z, int'(c.end_a), c.draw);
            OP_DIAG:  shadow_diag(x, y, int'(c.end_a), int'(c.end_b), c.axis);
            OP_FILL: begin
                for (int i = 0; i < ROWS; i++)
                    shadow_rows[i] = c.pattern[CUBE-1:0];
            end
            OP_SAVE: begin
                for (int i = 0; i < ROWS; i++)
                    shadow_saved[i] = shadow_rows[i];
            end
            OP_RESTORE: begin
                for (int i = 0; i < ROWS; i++)
                    shadow_rows[i] = shadow_saved[i];
            end
            default: ;
        endcase
        return bit_out;
    endfunction

    function automatic cmd_t mk(logic [3:0] op, int x, int y, int z, int ea, int eb,
                                logic [1:0] ax, logic on, logic [4:0] pat);
        cmd_t c;
        c.op = op;
        c.x = x[3:0];
        c.y = y[3:0];
        c.z = z[3:0];
        c.end_a = ea[3:0];
        c.end_b = eb[3:0];
        c.axis = ax;
        c.draw = on;
        c.pattern = pat;
        return c;
    endfunction

    // mostly near the cube, sometimes anywhere in the 4-bit range
    function automatic int pick_coord();
        if ($urandom_range(0, 6) == 0)
            return int'($urandom_range(0, 15)) - 8;
        return int'($urandom_range(0, 6)) - 1;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   w;
        logic [3:0] op;
        w = $urandom_range(0, 99);
        if (w < 33)      op = OP_READ;
        else if (w < 43) op = OP_SET;
        else if (w < 50) op = OP_CLEAR;
        else if (w < 57) op = OP_FLIP;
        else if (w < 64) op = OP_PLANE;
        else if (w < 75) op = OP_LINE;
        else if (w < 86) op = OP_DIAG;
        else if (w < 89) op = OP_FILL;
        else if (w < 93) op = OP_SAVE;
        else if (w < 97) op = OP_RESTORE;
        else             op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        c = mk(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2)),
               1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        return c;
    endfunction

    task automatic queue_cmd(cmd_t c);
        pend_q.push_back(c);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(posedge aclk);
    endtask

    // driver
    cmd_t cur_cmd;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(posedge aclk) begin
        cmd_t nxt;
        logic show;
        logic got;
        show = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                got = draw_and_read(cur_cmd);
                voxel_exp_q.push_back(got);
                if (cur_cmd.op == OP_READ && got)
                    reads_lit++;
                sent_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    nxt = pend_q.pop_front();
                    cur_cmd = nxt;
                    show = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                s_valid <= show;
                if (show) begin
                    s_operation  <= nxt.op;
                    s_x          <= nxt.x;
                    s_y          <= nxt.y;
                    s_z          <= nxt.z;
                    s_end_a      <= nxt.end_a;
                    s_end_b      <= nxt.end_b;
                    s_axis       <= nxt.axis;
                    s_draw_state <= nxt.draw;
                    s_pattern    <= nxt.pattern;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int rx_mode = RX_FREE;
    int rx_left = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_used && sent_cnt >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_SLOW);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (voxel_exp_q.size() == 0) begin
                errors++;
                $display("%0t: result transfer with no command pending, expected none, actual %0b",
                         $time, m_voxel_value);
            end else begin
                want = voxel_exp_q.pop_front();
                if (m_voxel_value !== want) begin
                    errors++;
                    $display("%0t: voxel_value mismatch, expected %0b, actual %0b",
                             $time, want, m_voxel_value);
                end
            end
        end
    end

    initial begin
        // cube dark after reset
        for (int i = 0; i < ROWS; i++) begin
            shadow_rows[i] = '0;
            shadow_saved[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fresh cube, corners, outside voxels
        queue_cmd(mk(OP_READ, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_SET, 0, 0, 0, 0, 0, AXIS_X, 1'b1, 5'd0));
        queue_cmd(mk(OP_SET, 4, 4, 4, 7, 7, AXIS_Z, 1'b0, 5'd31));
        queue_cmd(mk(OP_SET, 5, 0, 0, 0, 0, AXIS_X, 1'b1, 5'd0));
        queue_cmd(mk(OP_SET, -1, 2, 2, 0, 0, AXIS_X, 1'b1, 5'd0));
        queue_cmd(mk(OP_READ, -8, -8, -8, -8, -8, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_READ, 7, 7, 7, 7, 7, AXIS_NONE, 1'b1, 5'd31));
        queue_cmd(mk(OP_FLIP, 4, 4, 4, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_READ, 4, 4, 4, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_READ, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd0));
        // planes, including out-of-range index and unused axis
        queue_cmd(mk(OP_PLANE, 2, 0, 0, 0, 0, AXIS_X, 1'b1, 5'd0));
        queue_cmd(mk(OP_READ, 2, 3, 1, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_PLANE, 5, 0, 0, 0, 0, AXIS_Y, 1'b1, 5'd0));
        queue_cmd(mk(OP_PLANE, -1, 0, 0, 0, 0, AXIS_Z, 1'b1, 5'd0));
        queue_cmd(mk(OP_PLANE, 1, 0, 0, 0, 0, AXIS_NONE, 1'b1, 5'd0));
        queue_cmd(mk(OP_PLANE, 2, 0, 0, 0, 0, AXIS_Y, 1'b0, 5'd0));
        // axis lines with reversed endpoints partly outside
        queue_cmd(mk(OP_LINE, 1, 4, 3, -8, 0, AXIS_Y, 1'b1, 5'd0));
        queue_cmd(mk(OP_READ, 1, 0, 3, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_LINE, 1, 2, 7, 0, 0, AXIS_Z, 1'b0, 5'd0));
        // diagonals: shallow, steep across the range, each anchor
        queue_cmd(mk(OP_DIAG, 0, 0, 0, 4, 2, AXIS_Z, 1'b0, 5'd0));
        queue_cmd(mk(OP_READ, 2, 1, 3, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_DIAG, -3, 7, 0, 6, -8, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_DIAG, 4, 0, 0, 0, 4, AXIS_Y, 1'b0, 5'd0));
        queue_cmd(mk(OP_DIAG, 0, 0, 0, 4, 4, AXIS_NONE, 1'b0, 5'd0));
        // save, fill, restore, unused codes
        queue_cmd(mk(OP_SAVE, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_FILL, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd31));
        queue_cmd(mk(OP_READ, 3, 3, 3, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_RESTORE, 0, 0, 0, 0, 0, AXIS_X, 1'b0, 5'd0));
        queue_cmd(mk(OP_UNUSED_LO, 0, 0, 0, 0, 0, AXIS_X, 1'b1, 5'd31));
        queue_cmd(mk(OP_UNUSED_HI, -8, 7, -8, 7, -8, AXIS_NONE, 1'b1, 5'd31));
        wait_drained();

        for (int i = 0; i < 500; i++)
            queue_cmd(random_cmd());
        // sender pauses until the block has returned everything
        wait_drained();
        for (int i = 0; i < 500; i++)
            queue_cmd(random_cmd());
        wait_drained();
        repeat (60) @(posedge aclk);

        if (voxel_exp_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived, expected %0d, actual 0",
                     $time, voxel_exp_q.size(), voxel_exp_q.size());
        end
        $display("%0d draw commands transferred, %0d results checked", sent_cnt, results_seen);
        $display("%0d reads found a lit voxel, one long output hold-off applied", reads_lit);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d of %0d results in", results_seen, items_queued);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
